### src/ustc_pkg.sv
// Shared constants, tables and widths for the seconds-to-calendar converter.
package ustc_pkg;

  localparam int BASE_YEAR = 2000;

  localparam int SEC_W   = 32;
  localparam int DAY_W   = 16;
  localparam int TOD_W   = 17;
  localparam int DOY_W   = 9;
  localparam int K_W     = 8;
  localparam int YEAR_TAB = 140;

  localparam int SECOND_W = 6;
  localparam int MINUTE_W = 6;
  localparam int HOUR_W   = 5;
  localparam int DAY_OF_MONTH_W = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 12;

  // Exact reciprocals: floor(x * M >> SH) == floor(x / D) over the input range.
  localparam logic [25:0] M675  = 26'd50903317;  // days:   (secs >> 7) / 675
  localparam int          SH675 = 35;
  localparam logic [16:0] M366  = 17'd91679;     // years:  days / 366, lower bound
  localparam int          SH366 = 25;
  localparam logic [13:0] M225  = 14'd9321;      // hours:  (tod >> 4) / 225
  localparam int          SH225 = 21;
  localparam logic [10:0] M15   = 11'd1093;      // minutes: (rem >> 2) / 15
  localparam int          SH15  = 14;

  localparam logic [9:0]  DAY_DIV   = 10'd675;
  localparam logic [11:0] SEC_HOUR  = 12'd3600;
  localparam logic [5:0]  SEC_MIN   = 6'd60;

  typedef logic [YEAR_TAB-1:0][DAY_W-1:0] ystart_tab_t;
  typedef logic [YEAR_TAB-1:0]            yleap_tab_t;
  typedef logic [11:0][DOY_W-1:0]         mstart_row_t;

  function automatic logic is_leap(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic ystart_tab_t build_year_start();
    ystart_tab_t t;
    int acc;
    acc = 0;
    for (int k = 0; k < YEAR_TAB; k++) begin
      t[k] = DAY_W'(acc);
      acc  = acc + (is_leap(BASE_YEAR + k) ? 366 : 365);
    end
    return t;
  endfunction

  function automatic yleap_tab_t build_year_leap();
    yleap_tab_t t;
    for (int k = 0; k < YEAR_TAB; k++) begin
      t[k] = is_leap(BASE_YEAR + k);
    end
    return t;
  endfunction

  localparam ystart_tab_t YEAR_START = build_year_start();
  localparam yleap_tab_t  YEAR_LEAP  = build_year_leap();

  // First day of each month within the year, December first in the list.
  localparam mstart_row_t MSTART_COMMON = {
    9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
    9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
  };
  localparam mstart_row_t MSTART_LEAP = {
    9'd335, 9'd305, 9'd274, 9'd244, 9'd213, 9'd182,
    9'd152, 9'd121, 9'd91,  9'd60,  9'd31,  9'd0
  };

endpackage

### src/ustc_secs_if.sv
// Input channel: one second count per beat.
interface ustc_secs_if;
  import ustc_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEC_W-1:0] seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

### src/ustc_cal_if.sv
// Output channel: one broken-down date and time per beat.
interface ustc_cal_if;
  import ustc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [SECOND_W-1:0]       second_of_minute;
  logic [MINUTE_W-1:0]       minute_of_hour;
  logic [HOUR_W-1:0]         hour_of_day;
  logic [DAY_OF_MONTH_W-1:0] day_of_month;
  logic [MONTH_W-1:0]        month_index;
  logic [YEAR_W-1:0]         calendar_year;

  modport source (
    output valid, output second_of_minute, output minute_of_hour, output hour_of_day,
    output day_of_month, output month_index, output calendar_year, input ready
  );
  modport sink (
    input valid, input second_of_minute, input minute_of_hour, input hour_of_day,
    input day_of_month, input month_index, input calendar_year, output ready
  );
endinterface

### src/utc_seconds_to_calendar_unit.sv
// Seconds-since-base-year to Gregorian date and time converter, top level.
// Takes one beat per clock unless the output beat is stalled, and returns one
// result beat per input beat, in order. The day split takes two stages (a
// reciprocal multiply by 1/675 after a shift by 7, then a remainder fix); the
// time of day and the date then run side by side for four stages each. The
// year comes from floor(days/366) plus at most one, checked against a table of
// year start days; the month from parallel compares with the month start
// table. The whole pipeline advances together and holds while the output beat
// waits, so a stall drops and repeats nothing.
module utc_seconds_to_calendar_unit (
  input  logic     clk,
  input  logic     rst,
  ustc_secs_if.sink  secs_ch,
  ustc_cal_if.source cal_ch
);
  import ustc_pkg::*;

  logic             en;
  logic             v2;
  logic [DAY_W-1:0] days2;
  logic [TOD_W-1:0] tod2;

  assign en            = !cal_ch.valid || cal_ch.ready;
  assign secs_ch.ready = en;

  ustc_daysplit u_daysplit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (secs_ch.valid),
    .secs      (secs_ch.seconds_since_epoch),
    .out_valid (v2),
    .days      (days2),
    .tod       (tod2)
  );

  ustc_clock u_clock (
    .clk              (clk),
    .en               (en),
    .tod              (tod2),
    .second_of_minute (cal_ch.second_of_minute),
    .minute_of_hour   (cal_ch.minute_of_hour),
    .hour_of_day      (cal_ch.hour_of_day)
  );

  ustc_date u_date (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (v2),
    .days          (days2),
    .out_valid     (cal_ch.valid),
    .day_of_month  (cal_ch.day_of_month),
    .month_index   (cal_ch.month_index),
    .calendar_year (cal_ch.calendar_year)
  );
endmodule

### src/ustc_daysplit.sv
// Two-stage split of the second count into whole days and second of day.
module ustc_daysplit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [ustc_pkg::SEC_W-1:0] secs,
  output logic                      out_valid,
  output logic [ustc_pkg::DAY_W-1:0] days,
  output logic [ustc_pkg::TOD_W-1:0] tod
);
  import ustc_pkg::*;

  logic [24:0]      q0_next;
  logic [50:0]      prod;
  logic             v1;
  logic [DAY_W-1:0] est;
  logic [24:0]      q0;
  logic [6:0]       lo7;

  logic [25:0]      back;
  logic [24:0]      diff;
  logic [10:0]      r;
  logic             over;
  logic [10:0]      r_fix;

  assign q0_next = secs[SEC_W-1:7];
  assign prod    = 51'(q0_next) * 51'(M675);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      est <= prod[SH675 +: DAY_W];
      q0  <= q0_next;
      lo7 <= secs[6:0];
    end
  end

  assign back  = 26'(est) * 26'(DAY_DIV);
  assign diff  = q0 - back[24:0];
  assign r     = diff[10:0];
  assign over  = r >= 11'(DAY_DIV);
  assign r_fix = over ? (r - 11'(DAY_DIV)) : r;

  always_ff @(posedge clk) begin
    if (en) begin
      days <= over ? (est + DAY_W'(1)) : est;
      tod  <= {r_fix[9:0], lo7};
    end
  end
endmodule

### src/ustc_clock.sv
// Four-stage split of the second of day into hour, minute and second.
module ustc_clock (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ustc_pkg::TOD_W-1:0]    tod,
  output logic [ustc_pkg::SECOND_W-1:0] second_of_minute,
  output logic [ustc_pkg::MINUTE_W-1:0] minute_of_hour,
  output logic [ustc_pkg::HOUR_W-1:0]   hour_of_day
);
  import ustc_pkg::*;

  logic [26:0]         hprod;
  logic [TOD_W-1:0]    tod3;
  logic [HOUR_W-1:0]   hour3;

  logic [TOD_W-1:0]    hsec;
  logic [TOD_W-1:0]    rem_full;
  logic [11:0]         rem4;
  logic [HOUR_W-1:0]   hour4;

  logic [20:0]         mprod;
  logic [11:0]         rem5;
  logic [HOUR_W-1:0]   hour5;
  logic [MINUTE_W-1:0] min5;

  logic [11:0]         msec;
  logic [11:0]         sec_full;

  assign hprod = 27'(tod[TOD_W-1:4]) * 27'(M225);

  always_ff @(posedge clk) begin
    if (en) begin
      tod3  <= tod;
      hour3 <= hprod[SH225 +: HOUR_W];
    end
  end

  assign hsec     = TOD_W'(hour3) * TOD_W'(SEC_HOUR);
  assign rem_full = tod3 - hsec;

  always_ff @(posedge clk) begin
    if (en) begin
      rem4  <= rem_full[11:0];
      hour4 <= hour3;
    end
  end

  assign mprod = 21'(rem4[11:2]) * 21'(M15);

  always_ff @(posedge clk) begin
    if (en) begin
      rem5  <= rem4;
      hour5 <= hour4;
      min5  <= mprod[SH15 +: MINUTE_W];
    end
  end

  assign msec     = 12'(min5) * 12'(SEC_MIN);
  assign sec_full = rem5 - msec;

  always_ff @(posedge clk) begin
    if (en) begin
      second_of_minute <= sec_full[SECOND_W-1:0];
      minute_of_hour   <= min5;
      hour_of_day      <= hour5;
    end
  end
endmodule

### src/ustc_date.sv
// Four-stage split of the day count into year, month and day of month.
module ustc_date (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [ustc_pkg::DAY_W-1:0]          days,
  output logic                                out_valid,
  output logic [ustc_pkg::DAY_OF_MONTH_W-1:0] day_of_month,
  output logic [ustc_pkg::MONTH_W-1:0]        month_index,
  output logic [ustc_pkg::YEAR_W-1:0]         calendar_year
);
  import ustc_pkg::*;

  logic [32:0]        yprod;
  logic               v3;
  logic [DAY_W-1:0]   days3;
  logic [K_W-1:0]     klo3;

  logic [K_W-1:0]     khi;
  logic [DAY_W-1:0]   st_lo;
  logic [DAY_W-1:0]   st_hi;
  logic               ge;
  logic [K_W-1:0]     k_sel;
  logic [DAY_W-1:0]   doy_full;
  logic               v4;
  logic [K_W-1:0]     k4;
  logic [DOY_W-1:0]   doy4;
  logic               leap4;

  mstart_row_t        ms4;
  logic [MONTH_W-1:0] m_next;
  logic               v5;
  logic [K_W-1:0]     k5;
  logic [DOY_W-1:0]   doy5;
  logic               leap5;
  logic [MONTH_W-1:0] m5;

  mstart_row_t        ms5;
  logic [DOY_W-1:0]   dom_full;

  // Year offset is floor(days / 366) or one more.
  assign yprod = 33'(days) * 33'(M366);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v3        <= in_valid;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      days3 <= days;
      klo3  <= yprod[SH366 +: K_W];
    end
  end

  assign khi      = klo3 + K_W'(1);
  assign st_lo    = YEAR_START[klo3];
  assign st_hi    = YEAR_START[khi];
  assign ge       = days3 >= st_hi;
  assign k_sel    = ge ? khi : klo3;
  assign doy_full = days3 - (ge ? st_hi : st_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      k4    <= k_sel;
      doy4  <= doy_full[DOY_W-1:0];
      leap4 <= YEAR_LEAP[k_sel];
    end
  end

  assign ms4 = leap4 ? MSTART_LEAP : MSTART_COMMON;

  always_comb begin
    m_next = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy4 >= ms4[i]) m_next = MONTH_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k5    <= k4;
      doy5  <= doy4;
      leap5 <= leap4;
      m5    <= m_next;
    end
  end

  assign ms5      = leap5 ? MSTART_LEAP : MSTART_COMMON;
  assign dom_full = doy5 - ms5[m5];

  always_ff @(posedge clk) begin
    if (en) begin
      day_of_month  <= dom_full[DAY_OF_MONTH_W-1:0];
      month_index   <= m5;
      calendar_year <= YEAR_W'(BASE_YEAR) + YEAR_W'(k5);
    end
  end
endmodule
